### src/plob_pkg.sv
`timescale 1ns / 1ps
package plob_pkg;

    localparam int ORDER_SLOTS     = 1048576;
    localparam int BOOKS           = 1024;
    localparam int LEVELS_PER_SIDE = 64;

    localparam int ORD_AW  = $clog2(ORDER_SLOTS);
    localparam int BOOK_W  = $clog2(BOOKS);
    localparam int SIDX_W  = BOOK_W + 1;
    localparam int SIDES   = 2 * BOOKS;
    localparam int LVL_IW  = $clog2(LEVELS_PER_SIDE);
    localparam int LVL_CW  = LVL_IW + 1;
    localparam int LVL_AW  = SIDX_W + LVL_IW;
    localparam int LVL_DEPTH = SIDES * LEVELS_PER_SIDE;
    localparam int CNT_W   = 21;

    localparam logic [LVL_CW-1:0] LVL_MAX   = LVL_CW'(LEVELS_PER_SIDE);
    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        M_ADD       = 3'd0,
        M_EXEC      = 3'd1,
        M_EXEC_PX   = 3'd2,
        M_CANCEL    = 3'd3,
        M_DELETE    = 3'd4,
        M_REPLACE   = 3'd5,
        M_REPL_MOVE = 3'd6,
        M_MODIFY    = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        EV_ADDED   = 2'd0,
        EV_UPDATED = 2'd1,
        EV_DELETED = 2'd2
    } t_level_event;

    typedef struct packed {
        logic [2:0]  mode;
        logic [19:0] order_id;
        logic [19:0] new_order_id;
        logic [9:0]  symbol;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  level_event;
        logic [9:0]  book_symbol;
        logic        level_side;
        logic [31:0] level_price;
        logic [31:0] level_volume;
        logic [20:0] level_orders;
        logic        is_top;
        logic [31:0] executed_quantity;
        logic [31:0] executed_price;
        logic        overflow;
        logic        last;
    } t_out_item;

    // one order table entry
    typedef struct packed {
        logic [SIDX_W-1:0] sidx;
        logic [31:0]       price;
        logic [31:0]       qty;
    } t_ord_word;

    // one price level entry
    typedef struct packed {
        logic [31:0]      price;
        logic [31:0]      vol;
        logic [CNT_W-1:0] cnt;
    } t_lvl_word;

    // request to the level unit
    typedef struct packed {
        logic              is_add;
        logic [SIDX_W-1:0] sidx;
        logic [31:0]       price;
        logic [31:0]       qty;
        logic              drop;
    } t_lvl_cmd;

    // answer from the level unit
    typedef struct packed {
        t_level_event     ev;
        logic [31:0]      vol;
        logic [CNT_W-1:0] cnt;
        logic             top;
        logic             ovf;
    } t_lvl_res;

    typedef enum logic [3:0] {
        L_CLEAR, L_IDLE, L_CNT, L_SCAN, L_CMP, L_MISS, L_SHUP_RD, L_SHUP_WR,
        L_INS, L_HIT, L_SHDN_RD, L_SHDN_WR, L_DONE
    } t_lvl_state;

    typedef enum logic [2:0] {
        T_IDLE, T_ORD, T_OP1, T_W1, T_E1, T_OP2, T_W2, T_E2
    } t_top_state;

endpackage

### src/plob_if.sv
`timescale 1ns / 1ps
interface plob_in_if import plob_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface plob_out_if import plob_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/plob_order_mem.sv
`timescale 1ns / 1ps
module plob_order_mem import plob_pkg::*; (
    input  logic              i_clk,
    input  logic [ORD_AW-1:0] i_rd_addr,
    output t_ord_word         o_rd_data,
    input  logic              i_wr_en,
    input  logic [ORD_AW-1:0] i_wr_addr,
    input  t_ord_word         i_wr_data
);
    t_ord_word r_mem [ORDER_SLOTS];
    t_ord_word r_rd;

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;
endmodule

### src/plob_level_unit.sv
`timescale 1ns / 1ps
module plob_level_unit import plob_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_lvl_cmd i_cmd,
    output logic     o_ready,
    output logic     o_done,
    output t_lvl_res o_res
);
    t_lvl_word r_lvl [LVL_DEPTH];
    logic [LVL_CW-1:0] r_cnt_mem [SIDES];

    t_lvl_state r_state, n_state;
    t_lvl_cmd   r_cmd, n_cmd;
    logic [LVL_CW-1:0] r_n, n_n, r_i, n_i, r_pos, n_pos;
    logic [SIDX_W-1:0] r_clr, n_clr;
    t_lvl_word r_word, n_word;
    t_lvl_res  r_res, n_res;

    t_lvl_word         r_lvl_rd;
    logic [LVL_CW-1:0] r_cnt_rd;
    logic [LVL_IW-1:0] lvl_rd_idx, lvl_wr_idx;
    logic              lvl_we, cnt_we;
    t_lvl_word         lvl_wd;
    logic [SIDX_W-1:0] cnt_rd_addr, cnt_wr_addr;
    logic [LVL_CW-1:0] cnt_wd;
    logic [32:0]       add_sum;
    t_lvl_word         upd;

    // level and count stores
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lvl[{r_cmd.sidx, lvl_wr_idx}] <= lvl_wd;
        end
        r_lvl_rd <= r_lvl[{r_cmd.sidx, lvl_rd_idx}];
        if (cnt_we) begin
            r_cnt_mem[cnt_wr_addr] <= cnt_wd;
        end
        r_cnt_rd <= r_cnt_mem[cnt_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_cmd  <= n_cmd;
        r_n    <= n_n;
        r_i    <= n_i;
        r_pos  <= n_pos;
        r_word <= n_word;
        r_res  <= n_res;
    end

    // saturating update of a hit level
    always_comb begin
        add_sum = {1'b0, r_word.vol} + {1'b0, r_cmd.qty};
        upd     = r_word;
        if (r_cmd.is_add) begin
            upd.vol = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
            if (r_word.cnt < COUNT_MAX) upd.cnt = r_word.cnt + 1'b1;
        end else begin
            upd.vol = (r_word.vol > r_cmd.qty) ? r_word.vol - r_cmd.qty : 32'd0;
            if (r_cmd.drop && r_word.cnt != '0) upd.cnt = r_word.cnt - 1'b1;
        end
    end

    // sequencer: reset clear, count read, scan, shift, write back
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_n     = r_n;
        n_i     = r_i;
        n_pos   = r_pos;
        n_clr   = r_clr;
        n_word  = r_word;
        n_res   = r_res;
        lvl_rd_idx  = r_i[LVL_IW-1:0];
        lvl_wr_idx  = r_i[LVL_IW-1:0];
        lvl_we      = 1'b0;
        lvl_wd      = r_lvl_rd;
        cnt_rd_addr = r_cmd.sidx;
        cnt_wr_addr = r_cmd.sidx;
        cnt_we      = 1'b0;
        cnt_wd      = '0;
        o_done      = 1'b0;
        unique case (r_state)
            L_CLEAR: begin
                cnt_we      = 1'b1;
                cnt_wr_addr = r_clr;
                n_clr       = r_clr + 1'b1;
                if (r_clr == SIDX_W'(SIDES - 1)) n_state = L_IDLE;
            end
            L_IDLE: begin
                cnt_rd_addr = i_cmd.sidx;
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_state = L_CNT;
                end
            end
            L_CNT: begin
                n_n     = (r_cnt_rd > LVL_MAX) ? LVL_MAX : r_cnt_rd;
                n_i     = '0;
                n_state = L_SCAN;
            end
            L_SCAN: begin
                if (r_i == r_n) begin
                    n_pos   = r_i;
                    n_state = L_MISS;
                end else begin
                    n_state = L_CMP;
                end
            end
            L_CMP: begin
                if (r_lvl_rd.price == r_cmd.price) begin
                    n_pos   = r_i;
                    n_word  = r_lvl_rd;
                    n_state = L_HIT;
                end else if (r_cmd.sidx[0] ? (r_lvl_rd.price < r_cmd.price)
                                           : (r_lvl_rd.price > r_cmd.price)) begin
                    n_pos   = r_i;
                    n_state = L_MISS;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = L_SCAN;
                end
            end
            L_MISS: begin
                n_res = '{ev: EV_UPDATED, vol: '0, cnt: '0, top: 1'b0, ovf: 1'b0};
                if (!r_cmd.is_add) begin
                    n_state = L_DONE;
                end else if (r_n >= LVL_MAX) begin
                    n_res.ev  = EV_ADDED;
                    n_res.ovf = 1'b1;
                    n_state   = L_DONE;
                end else begin
                    n_i     = r_n;
                    n_state = (r_n == r_pos) ? L_INS : L_SHUP_RD;
                end
            end
            // open a slot: move entries up from the end
            L_SHUP_RD: begin
                lvl_rd_idx = LVL_IW'(r_i - 1'b1);
                n_state    = L_SHUP_WR;
            end
            L_SHUP_WR: begin
                lvl_we  = 1'b1;
                n_i     = r_i - 1'b1;
                n_state = ((r_i - 1'b1) == r_pos) ? L_INS : L_SHUP_RD;
            end
            L_INS: begin
                lvl_we     = 1'b1;
                lvl_wr_idx = r_pos[LVL_IW-1:0];
                lvl_wd     = '{price: r_cmd.price, vol: r_cmd.qty, cnt: CNT_W'(1)};
                cnt_we     = 1'b1;
                cnt_wd     = r_n + 1'b1;
                n_res = '{ev: EV_ADDED, vol: r_cmd.qty, cnt: CNT_W'(1),
                          top: (r_pos == r_n), ovf: 1'b0};
                n_state = L_DONE;
            end
            L_HIT: begin
                lvl_we     = 1'b1;
                lvl_wr_idx = r_pos[LVL_IW-1:0];
                lvl_wd     = upd;
                n_res = '{ev: EV_UPDATED, vol: upd.vol, cnt: upd.cnt,
                          top: (r_pos == r_n - 1'b1), ovf: 1'b0};
                n_state = L_DONE;
                if (!r_cmd.is_add && upd.vol == '0) begin
                    n_res.ev = EV_DELETED;
                    cnt_we   = 1'b1;
                    cnt_wd   = r_n - 1'b1;
                    n_i      = r_pos;
                    if ((r_pos + 1'b1) < r_n) n_state = L_SHDN_RD;
                end
            end
            // close the gap: move entries down
            L_SHDN_RD: begin
                lvl_rd_idx = LVL_IW'(r_i + 1'b1);
                n_state    = L_SHDN_WR;
            end
            L_SHDN_WR: begin
                lvl_we  = 1'b1;
                n_i     = r_i + 1'b1;
                n_state = ((r_i + 2'd2) < r_n) ? L_SHDN_RD : L_DONE;
            end
            L_DONE: begin
                o_done  = 1'b1;
                n_state = L_IDLE;
            end
            default: n_state = L_IDLE;
        endcase
    end

    assign o_ready = (r_state == L_IDLE);
    assign o_res   = r_res;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == L_IDLE) else $error("level request while busy");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == L_INS |-> r_n < LVL_MAX) else $error("insert into full side");
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == L_CMP |-> r_i < r_n) else $error("scan past side length");
endmodule

### src/price_level_order_book.sv
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// i_in      in   valid/ready    mode, order ids, symbol, side, price, quantity
// o_out     out  valid/ready    level event, level state, execution, overflow, last
//
// One event's time grows with the side depth scanned plus entries shifted per
// level operation, most for a replace on full sides; events are taken one at a
// time. Both level operations share one scan/shift unit with one read and one
// write level-store port. After reset a clearing pass zeros all 2048 side
// counts; no request is taken meanwhile. Results wait in an output register;
// a stalled sink holds the sequencer whenever a result is due while it is full.
module price_level_order_book import plob_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    plob_in_if.sink        i_in,
    plob_out_if.source     o_out
);
    t_top_state r_state, n_state;
    t_in_item   r_req, n_req;
    t_ord_word  r_ord, n_ord;
    logic [31:0] r_q, n_q;
    logic [BOOK_W-1:0] r_sym, n_sym;
    logic        r_side, n_side;
    logic [31:0] r_px, n_px;
    t_lvl_res    r_res, n_res;
    logic        r_ov, n_ov;
    t_out_item   r_out, n_out;

    t_ord_word   ord_rd, ord_wd;
    logic        ord_we;
    logic [ORD_AW-1:0] ord_wa;
    logic        lvl_start, lvl_ready, lvl_done;
    t_lvl_cmd    lvl_cmd;
    t_lvl_res    lvl_res;
    logic        out_free, accept;
    logic [31:0] rest;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign rest     = r_ord.qty - r_q;

    plob_order_mem u_ord (
        .i_clk     (i_clk),
        .i_rd_addr (i_in.data.order_id[ORD_AW-1:0]),
        .o_rd_data (ord_rd),
        .i_wr_en   (ord_we),
        .i_wr_addr (ord_wa),
        .i_wr_data (ord_wd)
    );

    plob_level_unit u_lvl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lvl_start),
        .i_cmd   (lvl_cmd),
        .o_ready (lvl_ready),
        .o_done  (lvl_done),
        .o_res   (lvl_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_req  <= n_req;
        r_ord  <= n_ord;
        r_q    <= n_q;
        r_sym  <= n_sym;
        r_side <= n_side;
        r_px   <= n_px;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // event sequencer
    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_ord   = r_ord;
        n_q     = r_q;
        n_sym   = r_sym;
        n_side  = r_side;
        n_px    = r_px;
        n_res   = r_res;
        n_out   = r_out;
        n_ov    = r_ov && !o_out.ready;
        ord_we  = 1'b0;
        ord_wa  = r_req.order_id[ORD_AW-1:0];
        ord_wd  = r_ord;
        lvl_start = 1'b0;
        lvl_cmd = '{is_add: 1'b0, sidx: {r_sym, r_side}, price: r_px, qty: r_q,
                    drop: (rest == '0)};
        unique case (r_state)
            T_IDLE: begin
                if (accept) begin
                    n_req   = i_in.data;
                    n_state = T_ORD;
                end
            end
            T_ORD: begin
                n_ord = ord_rd;
                if (r_req.mode == M_ADD) begin
                    n_sym  = r_req.symbol[BOOK_W-1:0];
                    n_side = r_req.side;
                    n_px   = r_req.price;
                    n_q    = r_req.quantity;
                end else begin
                    n_sym  = ord_rd.sidx[SIDX_W-1:1];
                    n_side = ord_rd.sidx[0];
                    n_px   = ord_rd.price;
                    if (r_req.mode >= M_DELETE) n_q = ord_rd.qty;
                    else n_q = (r_req.quantity < ord_rd.qty) ? r_req.quantity
                                                             : ord_rd.qty;
                end
                n_state = T_OP1;
            end
            T_OP1: begin
                lvl_start      = lvl_ready;
                lvl_cmd.is_add = (r_req.mode == M_ADD);
                if (r_req.mode >= M_DELETE) lvl_cmd.drop = 1'b1;
                if (r_req.mode inside {[M_EXEC:M_CANCEL]}) begin
                    ord_we     = lvl_ready;
                    ord_wd.qty = rest;
                end
                if (lvl_ready) n_state = T_W1;
            end
            T_W1: begin
                if (lvl_done) begin
                    n_res   = lvl_res;
                    n_state = T_E1;
                end
            end
            T_E1: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_out = '{level_event: r_res.ev, book_symbol: r_sym, level_side: r_side,
                              level_price: r_px, level_volume: r_res.vol,
                              level_orders: r_res.cnt, is_top: r_res.top,
                              executed_quantity: '0, executed_price: '0,
                              overflow: r_res.ovf, last: 1'b1};
                    n_state = T_IDLE;
                    case (r_req.mode)
                        M_ADD: begin
                            ord_we = 1'b1;
                            ord_wd = '{sidx: {r_sym, r_side}, price: r_px,
                                       qty: r_res.ovf ? 32'd0 : r_q};
                        end
                        M_EXEC: begin
                            n_out.executed_quantity = r_q;
                            n_out.executed_price    = r_px;
                        end
                        M_EXEC_PX: begin
                            n_out.executed_quantity = r_q;
                            n_out.executed_price    = r_req.price;
                        end
                        M_CANCEL, M_DELETE: ;
                        default: begin
                            if (r_req.quantity == '0) begin
                                if (r_req.mode == M_MODIFY) begin
                                    ord_we = 1'b1;
                                    ord_wd = '{sidx: r_ord.sidx, price: r_req.price,
                                               qty: 32'd0};
                                end
                            end else begin
                                n_out.last = 1'b0;
                                n_px = r_req.price;
                                n_q  = r_req.quantity;
                                if (r_req.mode == M_REPL_MOVE) begin
                                    n_sym  = r_req.symbol[BOOK_W-1:0];
                                    n_side = r_req.side;
                                end
                                n_state = T_OP2;
                            end
                        end
                    endcase
                end
            end
            T_OP2: begin
                lvl_start      = lvl_ready;
                lvl_cmd.is_add = 1'b1;
                if (lvl_ready) n_state = T_W2;
            end
            T_W2: begin
                if (lvl_done) begin
                    n_res   = lvl_res;
                    n_state = T_E2;
                end
            end
            T_E2: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_out = '{level_event: r_res.ev, book_symbol: r_sym, level_side: r_side,
                              level_price: r_px, level_volume: r_res.vol,
                              level_orders: r_res.cnt, is_top: r_res.top,
                              executed_quantity: '0, executed_price: '0,
                              overflow: r_res.ovf, last: 1'b1};
                    ord_we = 1'b1;
                    if (r_req.mode != M_MODIFY) ord_wa = r_req.new_order_id[ORD_AW-1:0];
                    ord_wd = '{sidx: {r_sym, r_side}, price: r_px,
                               qty: r_res.ovf ? 32'd0 : r_q};
                    n_state = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    assign i_in.ready  = (r_state == T_IDLE) && lvl_ready;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;
endmodule
